FILE: hdl/macd_signal_filter_top_macros.svh
// Assertion helpers for the MACD signal filter
`ifndef MACD_SIGNAL_FILTER_TOP_MACROS_SVH
`define MACD_SIGNAL_FILTER_TOP_MACROS_SVH

// same-cycle implication
`define MSF_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MSF_ASSERT_NXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/msf_pkg.sv
package msf_pkg;

   localparam int WFRAC    = 30;
   localparam int CFRAC    = 17;
   localparam int COEF_W   = 19;
   localparam int GUARD_W  = 7;
   localparam int RESULT_W = 32;

   localparam logic signed [RESULT_W-1:0] SAT_HI = {1'b0, {(RESULT_W - 1){1'b1}}};
   localparam logic signed [RESULT_W-1:0] SAT_LO = {1'b1, {(RESULT_W - 1){1'b0}}};

   function automatic logic [63:0] pow_at(input logic [63:0] w, input int idx);
      logic [63:0] p;
      p = 64'd1 << WFRAC;
      for (int k = 1; k < 64; k++) begin
         if (k <= idx) begin
            p = (p * w) >> WFRAC;
         end
      end
      return p;
   endfunction

   function automatic logic [63:0] denom_of(input logic [63:0] w, input int n);
      logic [63:0] d;
      d = 64'd1 << WFRAC;
      for (int k = 0; k < 64; k++) begin
         if (k < n) begin
            d = d + pow_at(w, k);
         end
      end
      return d;
   endfunction

endpackage

FILE: hdl/msf_fir.sv
module msf_fir
   import msf_pkg::*;
#(
   parameter int N  = 12,
   parameter int DW = 33
) (
   input  logic                                        clock,
   input  logic                                        load_prod,
   input  logic                                        load_sum,
   input  logic signed [DW-1:0]                        taps [N],
   output logic signed [DW+COEF_W+GUARD_W-CFRAC:0]     ema
);

   localparam int PROD_W = DW + COEF_W + 1;
   localparam int SUM_W  = PROD_W + GUARD_W;
   localparam int OUT_W  = SUM_W - CFRAC;

   localparam logic [63:0] W = ((64'(N) - 64'd1) << WFRAC) / (64'(N) + 64'd1);
   localparam logic [63:0] D = denom_of(W, N);
   localparam logic signed [SUM_W-1:0] HALF = SUM_W'(64'd1 << (CFRAC - 1));

   logic signed [PROD_W-1:0] prod_ff [N];
   logic signed [PROD_W-1:0] prod_in [N];
   logic signed [SUM_W-1:0]  acc;
   logic signed [OUT_W-1:0]  ema_ff;
   logic signed [OUT_W-1:0]  ema_in;

   for (genvar gi = 0; gi < N; gi++) begin : g_tap
      localparam logic [63:0] P   = pow_at(W, gi);
      localparam logic [63:0] NUM = (gi == 0) ? (P << 1) : P;
      localparam logic [63:0] C   = ((NUM << CFRAC) + (D >> 1)) / D;
      localparam logic signed [COEF_W:0] CS = (COEF_W + 1)'(C);
      assign prod_in[gi] = PROD_W'(taps[gi]) * PROD_W'(CS);
   end

   always_comb begin
      acc = HALF;
      for (int k = 0; k < N; k++) begin
         acc = acc + SUM_W'(prod_ff[k]);
      end
      ema_in = OUT_W'(acc >>> CFRAC);
   end

   always_ff @(posedge clock) begin
      if (load_prod) begin
         prod_ff <= prod_in;
      end
      if (load_sum) begin
         ema_ff <= ema_in;
      end
   end

   assign ema = ema_ff;

endmodule

FILE: hdl/macd_signal_filter_top.sv
// Channel   Ports                                                     Direction
// request   req_valid, req_stall, req_price                           in
// response  rsp_valid, rsp_stall, rsp_macd_value, rsp_signal_value   out
//
// One request per cycle while req_stall is low; each request passes the stages below in order.
// Seven register stages (price window, products, EMA sums, MACD window,
// signal products, signal sum, response) each hold one request.
// Synchronous reset clears stage valids and the warm-up count; the windows are
// not cleared. Requests before the warm-up count is reached give no response.
// rsp_stall holds only full stages; empty stages keep filling behind it.
`include "macd_signal_filter_top_macros.svh"

module macd_signal_filter_top
   import msf_pkg::*;
#(
   parameter int SHORT_PERIOD  = 12,
   parameter int LONG_PERIOD   = 26,
   parameter int SIGNAL_PERIOD = 9,
   parameter int PRICE_WIDTH   = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [PRICE_WIDTH-1:0]     req_price,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [RESULT_W-1:0] rsp_macd_value,
   output logic signed [RESULT_W-1:0] rsp_signal_value
);

   localparam int WIN_DEPTH  = (SHORT_PERIOD > LONG_PERIOD) ? SHORT_PERIOD : LONG_PERIOD;
   localparam int EMIT_COUNT = WIN_DEPTH + SIGNAL_PERIOD + 1;
   localparam int CNT_W      = $clog2(EMIT_COUNT + 1);
   localparam int TAP_W      = PRICE_WIDTH + 1;
   localparam int EMA_W      = TAP_W + COEF_W + 1 + GUARD_W - CFRAC;
   localparam int DIFF_W     = EMA_W + 1;
   localparam int SIG_W      = RESULT_W + COEF_W + 1 + GUARD_W - CFRAC;
   localparam int NSTAGE     = 6;

   localparam logic signed [DIFF_W-1:0] MACD_HI = DIFF_W'(SAT_HI);
   localparam logic signed [DIFF_W-1:0] MACD_LO = DIFF_W'(SAT_LO);
   localparam logic signed [SIG_W-1:0]  SIG_HI  = SIG_W'(SAT_HI);
   localparam logic signed [SIG_W-1:0]  SIG_LO  = SIG_W'(SAT_LO);

   logic [NSTAGE-1:0] valid_ff, valid_in;
   logic [NSTAGE-1:0] emit_ff, emit_in;
   logic [NSTAGE:0]   ready;
   logic [NSTAGE-1:0] move;
   logic              accept;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [PRICE_WIDTH-1:0]     price_window_ff [WIN_DEPTH];
   logic [PRICE_WIDTH-1:0]     price_window_in [WIN_DEPTH];
   logic signed [RESULT_W-1:0] macd_window_ff [SIGNAL_PERIOD];
   logic signed [RESULT_W-1:0] macd_window_in [SIGNAL_PERIOD];

   logic signed [TAP_W-1:0]    short_taps [SHORT_PERIOD];
   logic signed [TAP_W-1:0]    long_taps [LONG_PERIOD];
   logic signed [EMA_W-1:0]    ema_short, ema_long;
   logic signed [DIFF_W-1:0]   macd_diff;
   logic signed [RESULT_W-1:0] macd_sat;
   logic signed [SIG_W-1:0]    sig_ema;
   logic signed [RESULT_W-1:0] sig_sat;

   logic signed [RESULT_W-1:0] macd_s4_ff, macd_s5_ff;
   logic signed [RESULT_W-1:0] rsp_macd_ff, rsp_signal_ff;

   always_comb begin
      ready[NSTAGE] = !rsp_valid_ff || !rsp_stall;
      for (int k = NSTAGE - 1; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
      for (int k = 0; k < NSTAGE; k++) begin
         move[k] = valid_ff[k] && ready[k+1];
      end
   end

   assign accept    = req_valid && ready[0];
   assign req_stall = !ready[0];

   always_comb begin
      valid_in[0] = accept || (valid_ff[0] && !move[0]);
      emit_in[0]  = accept ? (count_ff >= CNT_W'(EMIT_COUNT - 1)) : emit_ff[0];
      for (int k = 1; k < NSTAGE; k++) begin
         valid_in[k] = move[k-1] || (valid_ff[k] && !move[k]);
         emit_in[k]  = move[k-1] ? emit_ff[k-1] : emit_ff[k];
      end
      count_in = count_ff;
      if (accept && (count_ff < CNT_W'(EMIT_COUNT))) begin
         count_in = count_ff + CNT_W'(1);
      end
      rsp_valid_in = move[NSTAGE-1] ? emit_ff[NSTAGE-1] : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // shift windows
   always_comb begin
      price_window_in[0] = req_price;
      for (int k = 1; k < WIN_DEPTH; k++) begin
         price_window_in[k] = price_window_ff[k-1];
      end
      macd_window_in[0] = macd_sat;
      for (int k = 1; k < SIGNAL_PERIOD; k++) begin
         macd_window_in[k] = macd_window_ff[k-1];
      end
   end

   for (genvar gs = 0; gs < SHORT_PERIOD; gs++) begin : g_short
      assign short_taps[gs] = $signed({1'b0, price_window_ff[gs]});
   end

   for (genvar gl = 0; gl < LONG_PERIOD; gl++) begin : g_long
      assign long_taps[gl] = $signed({1'b0, price_window_ff[gl]});
   end

   msf_fir #(.N(SHORT_PERIOD), .DW(TAP_W)) u_short_fir (
      .clock     (clock),
      .load_prod (move[0]),
      .load_sum  (move[1]),
      .taps      (short_taps),
      .ema       (ema_short)
   );

   msf_fir #(.N(LONG_PERIOD), .DW(TAP_W)) u_long_fir (
      .clock     (clock),
      .load_prod (move[0]),
      .load_sum  (move[1]),
      .taps      (long_taps),
      .ema       (ema_long)
   );

   always_comb begin
      macd_diff = DIFF_W'(ema_short) - DIFF_W'(ema_long);
      if (macd_diff > MACD_HI) begin
         macd_sat = SAT_HI;
      end else if (macd_diff < MACD_LO) begin
         macd_sat = SAT_LO;
      end else begin
         macd_sat = RESULT_W'(macd_diff);
      end
   end

   msf_fir #(.N(SIGNAL_PERIOD), .DW(RESULT_W)) u_signal_fir (
      .clock     (clock),
      .load_prod (move[3]),
      .load_sum  (move[4]),
      .taps      (macd_window_ff),
      .ema       (sig_ema)
   );

   always_comb begin
      if (sig_ema > SIG_HI) begin
         sig_sat = SAT_HI;
      end else if (sig_ema < SIG_LO) begin
         sig_sat = SAT_LO;
      end else begin
         sig_sat = RESULT_W'(sig_ema);
      end
   end

   always_ff @(posedge clock) begin
      emit_ff <= emit_in;
      if (accept) begin
         price_window_ff <= price_window_in;
      end
      if (move[2]) begin
         macd_window_ff <= macd_window_in;
      end
      if (move[3]) begin
         macd_s4_ff <= macd_window_ff[0];
      end
      if (move[4]) begin
         macd_s5_ff <= macd_s4_ff;
      end
      if (move[NSTAGE-1]) begin
         rsp_macd_ff   <= macd_s5_ff;
         rsp_signal_ff <= sig_sat;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_macd_value   = rsp_macd_ff;
   assign rsp_signal_value = rsp_signal_ff;

   `MSF_ASSERT_IMP(a_rsp_after_warmup, rsp_valid_ff, count_ff == CNT_W'(EMIT_COUNT), "response before warm-up")
   `MSF_ASSERT_IMP(a_full_stall, rsp_valid_ff && rsp_stall && (&valid_ff), req_stall, "request taken into a full pipeline")
   `MSF_ASSERT_NXT(a_count_step, accept && (count_ff < CNT_W'(EMIT_COUNT)), count_ff == $past(count_ff) + CNT_W'(1), "warm-up count missed a request")

endmodule

FILE: dv/macd_signal_filter_top_test.sv
`timescale 1ns / 1ps

module macd_signal_filter_top_test
   import msf_pkg::*;
();

   localparam int SHORT_N     = 12;
   localparam int LONG_N      = 26;
   localparam int SIGNAL_N    = 9;
   localparam int FIRST_PAIR  = LONG_N + SIGNAL_N + 1;
   localparam int HOLD_CYCLES = 120;
   localparam logic [63:0] HALF_LSB = 64'd1 << (CFRAC - 1);

   typedef struct packed {
      logic signed [RESULT_W-1:0] macd_val;
      logic signed [RESULT_W-1:0] signal_val;
   } macd_pair_type;

   typedef enum {STYLE_UNIFORM, STYLE_WALK, STYLE_STEP, STYLE_EXTREME} burst_style_type;

   logic                       clock;
   logic                       reset     = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [31:0]                req_price = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [RESULT_W-1:0] rsp_macd_value;
   logic signed [RESULT_W-1:0] rsp_signal_value;

   logic [63:0]                short_taps[SHORT_N];
   logic [63:0]                long_taps[LONG_N];
   logic [63:0]                signal_taps[SIGNAL_N];
   logic [31:0]                price_hist[LONG_N];
   logic signed [RESULT_W-1:0] macd_hist[SIGNAL_N];
   int                         samples_seen;

   macd_pair_type pending_pairs[$];
   int            errors;
   int            requests_sent;
   int            pairs_checked;
   int            send_idle_pct;
   int            stall_pct;
   bit            hold_req;
   int            hold_left;

   macd_signal_filter_top DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_price        (req_price),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_macd_value   (rsp_macd_value),
      .rsp_signal_value (rsp_signal_value)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic logic [63:0] fir_weight(input int n, input int idx);
      logic [63:0] w, p, d, sel;
      w   = (64'(n - 1) << WFRAC) / 64'(n + 1);
      p   = 64'd1 << WFRAC;
      d   = p;
      sel = '0;
      for (int i = 0; i < n; i++) begin
         if (i > 0) p = (p * w) >> WFRAC;
         d += p;
         if (i == idx) sel = (i == 0) ? 2 * p : p;
      end
      return ((sel << CFRAC) + d / 2) / d;
   endfunction

   function automatic logic signed [RESULT_W-1:0] clamp32(input logic signed [63:0] v);
      if (v > SAT_HI) return SAT_HI;
      if (v < SAT_LO) return SAT_LO;
      return v[RESULT_W-1:0];
   endfunction

   function automatic bit advance_filter(input logic [31:0] price,
                                         output macd_pair_type pair);
      logic [63:0]        acc_short, acc_long;
      logic signed [63:0] diff, acc_sig;
      for (int i = LONG_N - 1; i > 0; i--) price_hist[i] = price_hist[i - 1];
      price_hist[0] = price;
      acc_short = '0;
      acc_long  = '0;
      for (int i = 0; i < SHORT_N; i++) acc_short += short_taps[i] * price_hist[i];
      for (int i = 0; i < LONG_N; i++) acc_long += long_taps[i] * price_hist[i];
      diff = $signed((acc_short + HALF_LSB) >> CFRAC) - $signed((acc_long + HALF_LSB) >> CFRAC);
      for (int i = SIGNAL_N - 1; i > 0; i--) macd_hist[i] = macd_hist[i - 1];
      macd_hist[0] = clamp32(diff);
      acc_sig = 64'sd0;
      for (int i = 0; i < SIGNAL_N; i++) acc_sig += $signed(signal_taps[i]) * macd_hist[i];
      pair.macd_val   = macd_hist[0];
      pair.signal_val = clamp32((acc_sig + $signed(HALF_LSB)) >>> CFRAC);
      if (samples_seen < FIRST_PAIR) samples_seen++;
      return samples_seen >= FIRST_PAIR;
   endfunction

   task automatic send_price(input logic [31:0] price);
      macd_pair_type pair;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_price <= price;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      requests_sent++;
      if (advance_filter(price, pair)) pending_pairs.push_back(pair);
   endtask

   task automatic set_idling(input int send_pct, input int stall_in, input bit hold);
      req_valid <= 1'b0;
      @(negedge clock);
      send_idle_pct = send_pct;
      stall_pct     = stall_in;
      hold_req      = hold;
      @(posedge clock);
   endtask

   task automatic send_burst(input burst_style_type style, input int count);
      logic [31:0] level_a, level_b, price;
      int          run;
      level_a = $urandom;
      level_b = $urandom;
      price   = $urandom;
      run     = $urandom_range(1, 30);
      for (int i = 0; i < count; i++) begin
         case (style)
            STYLE_UNIFORM: price = $urandom;
            STYLE_WALK:    price = price + $urandom_range(0, 1 << 21) - (1 << 20);
            STYLE_STEP:    price = ((i / run) % 2) ? level_a : level_b;
            default:       price = $urandom_range(0, 1) ? 32'hFFFF_FFFF - $urandom_range(0, 255)
                                                        : $urandom_range(0, 255);
         endcase
         send_price(price);
      end
   endtask

   task automatic test_warmup();
      logic [31:0] patterns[8];
      patterns = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 32'h5A5A_5A5A,
                   32'h0000_0001, 32'h8000_0000, 32'h0000_FFFF, 32'hFFFF_0000};
      set_idling(0, 0, 1'b0);
      foreach (patterns[i]) send_price(patterns[i]);
      repeat (14) send_price(32'h0000_0000);
      repeat (FIRST_PAIR - 22) send_price(32'hFFFF_FFFF);
   endtask

   task automatic test_full_swings();
      repeat (13) send_price(32'h0000_0000);
      repeat (7) send_price(32'hFFFF_FFFF);
   endtask

   task automatic test_random_phase(input int send_pct, input int stall_in, input int items);
      int sent;
      int count;
      set_idling(send_pct, stall_in, 1'b0);
      sent = 0;
      while (sent < items) begin
         count = $urandom_range(5, 40);
         send_burst(burst_style_type'($urandom_range(0, 3)), count);
         sent += count;
      end
   endtask

   task automatic test_output_hold();
      set_idling(0, 0, 1'b1);
      send_burst(STYLE_UNIFORM, 40);
   endtask

   always @(posedge clock) begin
      if (hold_req) begin
         hold_req  = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   always @(posedge clock) begin : check_response
      macd_pair_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         pairs_checked++;
         if (pending_pairs.size() == 0) begin
            errors++;
            $display("%0t: unexpected response, expected none, got macd %0d signal %0d",
                     $time, rsp_macd_value, rsp_signal_value);
         end else begin
            want = pending_pairs.pop_front();
            if (rsp_macd_value !== want.macd_val) begin
               errors++;
               $display("%0t: macd mismatch, expected %0d, got %0d",
                        $time, want.macd_val, rsp_macd_value);
            end
            if (rsp_signal_value !== want.signal_val) begin
               errors++;
               $display("%0t: signal mismatch, expected %0d, got %0d",
                        $time, want.signal_val, rsp_signal_value);
            end
         end
      end
   end

   initial begin
      #2_400_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      foreach (short_taps[i]) short_taps[i] = fir_weight(SHORT_N, i);
      foreach (long_taps[i]) long_taps[i] = fir_weight(LONG_N, i);
      foreach (signal_taps[i]) signal_taps[i] = fir_weight(SIGNAL_N, i);
      foreach (price_hist[i]) price_hist[i] = '0;
      foreach (macd_hist[i]) macd_hist[i] = '0;
      samples_seen  = 0;
      errors        = 0;
      requests_sent = 0;
      pairs_checked = 0;
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_req      = 1'b0;
      hold_left     = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_warmup();
      test_full_swings();
      test_random_phase(0, 0, 160);
      test_random_phase(49, 0, 160);
      test_random_phase(0, 49, 160);
      test_random_phase(24, 24, 160);
      test_output_hold();

      req_valid <= 1'b0;
      while (pending_pairs.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("%0d price requests sent, %0d MACD/signal pairs checked", requests_sent,
               pairs_checked);
      $display("warm-up gate, full-scale swings, random bursts under idle/stall mixes, long hold");
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
